// ----- rtl/chdec_pkg.sv -----
`default_nettype none

package chdec_pkg;

  // Width of the chunk size counter.
  localparam int SIZE_BITS = 32;

  // Depth of the queue between the classifier and the parser.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [1:0] {
    ST_RUNNING   = 2'd0,
    ST_FINISHED  = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  // One classified input byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    logic       is_cr;
    logic       is_lf;
    logic       is_hex;
    logic [3:0] hex_val;
  } chdec_item_t;

  // Queue control between the stages.
  typedef struct packed {
    logic full;
    logic empty;
  } chdec_qstat_t;

endpackage

`default_nettype wire

// ----- rtl/chdec_if.sv -----
`default_nettype none

interface chdec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface chdec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       is_header;
  logic [1:0] status;

  modport source (output valid, output out_byte, output byte_valid, output is_header,
                  output status, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input is_header,
                  input status, output ready);
endinterface

interface chdec_cfg_if;
  logic valid;
  logic ready;
  logic forward_header;

  modport source (output valid, output forward_header, input ready);
  modport sink   (input valid, input forward_header, output ready);
endinterface

`default_nettype wire

// ----- rtl/chdec_front.sv -----
`default_nettype none

module chdec_front import chdec_pkg::*; (
  chdec_in_if.sink     rx,
  input  chdec_qstat_t qstat,
  output logic         push,
  output chdec_item_t  push_item
);

  logic [7:0] b;

  assign b         = rx.in_byte;
  assign rx.ready  = !qstat.full;
  assign push      = rx.valid && !qstat.full;

  // Classify the byte so the parser gets flags and a digit value along with the byte.
  always_comb begin
    push_item.data    = b;
    push_item.eoi     = rx.end_of_input;
    push_item.is_cr   = (b == CHAR_CR);
    push_item.is_lf   = (b == CHAR_LF);
    push_item.is_hex  = 1'b0;
    push_item.hex_val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      push_item.is_hex  = 1'b1;
      push_item.hex_val = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      push_item.is_hex  = 1'b1;
      push_item.hex_val = 4'(b[2:0] + 3'd1) + 4'd8;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/chdec_fifo.sv -----
`default_nettype none

module chdec_fifo import chdec_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  chdec_item_t  push_item,
  input  logic         pop,
  output chdec_item_t  head,
  output chdec_qstat_t qstat
);

  chdec_item_t      mem [QDEPTH];
  logic [QAW-1:0]   wptr;
  logic [QAW-1:0]   rptr;
  logic [QAW:0]     count;

  assign head        = mem[rptr];
  assign qstat.full  = (count == (QAW+1)'(QDEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/chdec_back.sv -----
`default_nettype none

module chdec_back import chdec_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  chdec_item_t  head,
  input  chdec_qstat_t qstat,
  output logic         pop,
  chdec_out_if.source  tx,
  chdec_cfg_if.sink    cfg
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SIZE,
    PH_SIZE_LF,
    PH_DATA,
    PH_TRAIL,
    PH_DONE
  } phase_t;

  phase_t               phase, phase_next;
  logic [1:0]           header_match, header_match_next;
  logic [SIZE_BITS-1:0] size_accum, size_accum_next;
  logic                 digits_ended, digits_ended_next;
  logic                 saw_digit, saw_digit_next;
  logic [SIZE_BITS-1:0] bytes_left, bytes_left_next;
  logic                 trail_first, trail_first_next;
  logic                 forward_header;

  logic    fwd, hdr, emit, hit;
  status_t st;

  assign pop       = !qstat.empty && (!tx.valid || tx.ready);
  assign cfg.ready = 1'b1;

  always_comb begin
    phase_next        = phase;
    header_match_next = header_match;
    size_accum_next   = size_accum;
    digits_ended_next = digits_ended;
    saw_digit_next    = saw_digit;
    bytes_left_next   = bytes_left;
    trail_first_next  = trail_first;
    fwd  = 1'b0;
    hdr  = 1'b0;
    emit = 1'b0;
    st   = ST_RUNNING;
    hit  = header_match[0] ? head.is_lf : head.is_cr;

    case (phase)
      PH_HEADER: begin
        fwd = forward_header;
        hdr = forward_header;
        if (hit && header_match == 2'd3) begin
          header_match_next = 2'd0;
          phase_next        = PH_SIZE;
          size_accum_next   = '0;
          digits_ended_next = 1'b0;
          saw_digit_next    = 1'b0;
        end else if (hit) begin
          header_match_next = header_match + 2'd1;
        end else begin
          header_match_next = {1'b0, head.is_cr};
        end
      end
      PH_SIZE: begin
        if (head.is_cr) begin
          if (!saw_digit || size_accum == '0) begin
            phase_next = PH_DONE;
            st         = ST_FINISHED;
            emit       = 1'b1;
          end else begin
            phase_next = PH_SIZE_LF;
          end
        end else if (digits_ended || !head.is_hex) begin
          digits_ended_next = 1'b1;
        end else if (size_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
          phase_next = PH_DONE;
          st         = ST_OVERFLOW;
          emit       = 1'b1;
        end else begin
          size_accum_next = {size_accum[SIZE_BITS-5:0], head.hex_val};
          saw_digit_next  = 1'b1;
        end
      end
      PH_SIZE_LF: begin
        bytes_left_next = size_accum;
        phase_next      = PH_DATA;
      end
      PH_DATA: begin
        fwd = 1'b1;
        if (bytes_left != '0) bytes_left_next = bytes_left - 1'b1;
        if (bytes_left <= SIZE_BITS'(1)) begin
          phase_next       = PH_TRAIL;
          trail_first_next = 1'b1;
        end
      end
      PH_TRAIL: begin
        trail_first_next = 1'b0;
        if (!trail_first) begin
          phase_next        = PH_SIZE;
          size_accum_next   = '0;
          digits_ended_next = 1'b0;
          saw_digit_next    = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (head.eoi) begin
      if (phase != PH_DONE && st == ST_RUNNING) begin
        st   = ST_TRUNCATED;
        emit = 1'b1;
      end
      phase_next        = PH_HEADER;
      header_match_next = 2'd0;
      size_accum_next   = '0;
      digits_ended_next = 1'b0;
      saw_digit_next    = 1'b0;
      bytes_left_next   = '0;
      trail_first_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_match   <= 2'd0;
      size_accum     <= '0;
      digits_ended   <= 1'b0;
      saw_digit      <= 1'b0;
      bytes_left     <= '0;
      trail_first    <= 1'b0;
      forward_header <= 1'b1;
      tx.valid       <= 1'b0;
    end else begin
      if (cfg.valid) forward_header <= cfg.forward_header;
      if (pop) begin
        phase        <= phase_next;
        header_match <= header_match_next;
        size_accum   <= size_accum_next;
        digits_ended <= digits_ended_next;
        saw_digit    <= saw_digit_next;
        bytes_left   <= bytes_left_next;
        trail_first  <= trail_first_next;
        tx.valid     <= fwd || emit;
      end else if (tx.ready) begin
        tx.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tx.out_byte   <= fwd ? head.data : 8'd0;
      tx.byte_valid <= fwd;
      tx.is_header  <= hdr;
      tx.status     <= st;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/http_chunked_body_decoder_top.sv -----
// A byte taken at the input is written into the queue, then into the output register,
// and only from there is it offered as a result.
// Throughput: one byte per cycle, sustained while the result side keeps taking results.
// A four-entry queue between the byte classifier and the parser absorbs short stalls.
// Reset is synchronous and active high: the queue empties, parsing restarts in the
// header phase and forward_header returns to 1.
`default_nettype none

module http_chunked_body_decoder_top import chdec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  chdec_in_if.sink    rx,
  chdec_out_if.source tx,
  chdec_cfg_if.sink   cfg
);

  // The front classifies each incoming byte (CR, LF, hex digit and its value)
  // and pushes it into the queue whenever the queue has room, so the input
  // side never waits on the parser directly.
  chdec_qstat_t qstat;
  logic         push;
  chdec_item_t  push_item;
  logic         pop;
  chdec_item_t  head;

  chdec_front u_front (
    .rx        (rx),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  // The queue decouples the two sides; a push and a pop may happen in the
  // same cycle, which keeps one byte per cycle flowing while results are taken.
  chdec_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // The back runs the header match, the chunk size parser and the data
  // counter. It pops a byte whenever its output register is free or being
  // emptied in the same cycle, and it also holds the configuration register.
  chdec_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .tx    (tx),
    .cfg   (cfg)
  );

endmodule

`default_nettype wire

// ----- rtl/chdec_checker.sv -----
`default_nettype none

module chdec_checker (
  input logic       clk,
  input logic       rst,
  input logic       tx_valid,
  input logic       tx_ready,
  input logic [7:0] tx_out_byte,
  input logic       tx_byte_valid,
  input logic       tx_is_header,
  input logic [1:0] tx_status
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid)
    else $error("result dropped while stalled");

  // A result without a byte exists only to report a status.
  a_status_only: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_byte_valid |-> tx_status != 2'd0)
    else $error("empty result with running status");

  // Header bytes are always carried bytes.
  a_header_byte: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_is_header |-> tx_byte_valid)
    else $error("header flag without a byte");

  // A result without a byte carries a zero byte.
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_byte_valid |-> tx_out_byte == 8'd0)
    else $error("nonzero byte in a status-only result");

endmodule

bind http_chunked_body_decoder_top chdec_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .tx_valid      (tx.valid),
  .tx_ready      (tx.ready),
  .tx_out_byte   (tx.out_byte),
  .tx_byte_valid (tx.byte_valid),
  .tx_is_header  (tx.is_header),
  .tx_status     (tx.status)
);

`default_nettype wire
